### sv/bsort_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter package
// Shared constants, codes, the store request bundle and the set size helper.
// ----------------------------------------------------------------------------
package bsort_pkg;

   // Largest set the store can hold.
   localparam int MAX_ITEMS = 1024;
   // Log2 of the largest power of two that does not exceed MAX_ITEMS.
   localparam int LOG_MAX   = $clog2(MAX_ITEMS + 1) - 1;
   localparam int MEM_DEPTH = 1 << LOG_MAX;
   localparam int ADDR_W    = LOG_MAX;
   localparam int CNT_W     = LOG_MAX + 1;
   localparam int DATA_W    = 32;

   localparam int SIZE_LOG2_W = 4;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = SIZE_LOG2_W;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SORT_ASCENDING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_LOG2      = 1'd1;

   // Request opcodes.
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UNLOAD = 1'b1;

   // One cycle of requests to the element store.
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [DATA_W-1:0] wr_data;
      logic              rd_en_a;
      logic [ADDR_W-1:0] rd_addr_a;
      logic              rd_en_b;
      logic [ADDR_W-1:0] rd_addr_b;
   } bsort_mem_req_type;

   // Set size selected by the size register, saturated to the store depth.
   function automatic logic [CNT_W-1:0] bsort_cfg_size(input logic [SIZE_LOG2_W-1:0] lg);
      logic [SIZE_LOG2_W-1:0] eff;
      eff = (int'(lg) > LOG_MAX) ? SIZE_LOG2_W'(LOG_MAX) : lg;
      return CNT_W'(1) << eff;
   endfunction

endpackage

### sv/bsort_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter channel interfaces
// Valid/ready channels for requests (load or unload) and sorted responses.
// ----------------------------------------------------------------------------
interface bsort_req_if;
   import bsort_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     op;
   logic signed [DATA_W-1:0] value;

   modport source (output valid, output op, output value, input ready);
   modport sink   (input valid, input op, input value, output ready);
endinterface

interface bsort_rsp_if;
   import bsort_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] sorted_value;
   logic                     last;

   modport source (output valid, output sorted_value, output last, input ready);
   modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

### sv/bsort_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter element store
// One write port and two registered read ports over the element memory.
// ----------------------------------------------------------------------------
module bsort_store (
   input  logic                          clock,
   input  bsort_pkg::bsort_mem_req_type  mem_req,
   output logic [bsort_pkg::DATA_W-1:0]  rd_data_a,
   output logic [bsort_pkg::DATA_W-1:0]  rd_data_b
);
   import bsort_pkg::*;

   logic [DATA_W-1:0] mem [MEM_DEPTH];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en_a) begin
         rd_a_ff <= mem[mem_req.rd_addr_a];
      end
      if (mem_req.rd_en_b) begin
         rd_b_ff <= mem[mem_req.rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sv/bsort_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter compare unit
// Signed compare of one pair; flags a swap when the pair is out of order.
// ----------------------------------------------------------------------------
module bsort_cmp (
   input  logic [bsort_pkg::DATA_W-1:0] lo_value,
   input  logic [bsort_pkg::DATA_W-1:0] hi_value,
   input  logic                         dir_up,
   output logic                         swap
);
   import bsort_pkg::*;

   logic signed [DATA_W-1:0] a;
   logic signed [DATA_W-1:0] b;

   assign a    = lo_value;
   assign b    = hi_value;
   // Ascending pairs swap when the lower entry is greater, descending the reverse.
   assign swap = dir_up ? (a > b) : (b > a);

endmodule

### sv/bsort_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter controller
// Load and unload handling, configuration registers and the sort sequencer.
// ----------------------------------------------------------------------------
module bsort_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   bsort_req_if.sink                            req,
   bsort_rsp_if.source                          rsp,
   input  logic                                 csr_we,
   input  logic [bsort_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bsort_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic [bsort_pkg::DATA_W-1:0]         rd_data_a,
   input  logic [bsort_pkg::DATA_W-1:0]         rd_data_b,
   input  logic                                 swap,
   output logic                                 dir_up,
   output bsort_pkg::bsort_mem_req_type         mem_req
);
   import bsort_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_READ  = 5'b00010,
      ST_CMP   = 5'b00100,
      ST_WR_LO = 5'b01000,
      ST_WR_HI = 5'b10000
   } bsort_state_type;

   bsort_state_type         state_ff, state_in;
   logic [CNT_W-1:0]        load_count_ff, load_count_in;
   logic [CNT_W-1:0]        read_ptr_ff, read_ptr_in;
   logic [CNT_W-1:0]        set_size_ff, set_size_in;
   logic                    draining_ff, draining_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic [ADDR_W-1:0]       j_ff, j_in;
   logic [ADDR_W-1:0]       pair_ff, pair_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    last_ff, last_in;
   logic                    sort_up_ff;
   logic [SIZE_LOG2_W-1:0]  size_log2_ff;

   logic                    req_accept;
   logic [CNT_W-1:0]        cfg_n;
   logic                    store_en;
   logic [ADDR_W-1:0]       drain_idx;
   logic                    drain_last;
   logic [ADDR_W-1:0]       j_mask;
   logic [ADDR_W-1:0]       pair_lo;
   logic [ADDR_W-1:0]       pair_hi;
   logic                    half_last;
   logic [ADDR_W-1:0]       adv_pair;
   logic [ADDR_W-1:0]       adv_j;
   logic [CNT_W-1:0]        adv_k;
   logic                    adv_done;

   assign req.ready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign req_accept  = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.last    = last_ff;
   assign rsp.sorted_value = rd_data_a;

   assign cfg_n      = bsort_cfg_size(size_log2_ff);
   assign store_en   = load_count_ff < cfg_n;
   assign drain_idx  = (read_ptr_ff >= set_size_ff) ? '0 : read_ptr_ff[ADDR_W-1:0];
   assign drain_last = ({1'b0, drain_idx} + CNT_W'(1)) >= set_size_ff;

   // Pair addressing: insert a zero at the bit of the current distance.
   assign j_mask  = j_ff - ADDR_W'(1);
   assign pair_lo = ((pair_ff & ~j_mask) << 1) | (pair_ff & j_mask);
   assign pair_hi = pair_lo | j_ff;
   assign dir_up  = ((CNT_W'(pair_lo) & k_ff) == '0) ? sort_up_ff : !sort_up_ff;
   assign half_last = pair_ff == (set_size_ff[CNT_W-1:1] - ADDR_W'(1));

   always_comb begin
      adv_pair = pair_ff + ADDR_W'(1);
      adv_j    = j_ff;
      adv_k    = k_ff;
      adv_done = 1'b0;
      if (half_last) begin
         adv_pair = '0;
         if (j_ff == ADDR_W'(1)) begin
            if (k_ff == set_size_ff) begin
               adv_done = 1'b1;
            end else begin
               adv_k = k_ff << 1;
               adv_j = k_ff[ADDR_W-1:0];
            end
         end else begin
            adv_j = j_ff >> 1;
         end
      end
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      read_ptr_in   = read_ptr_ff;
      set_size_in   = set_size_ff;
      draining_in   = draining_ff;
      k_in          = k_ff;
      j_in          = j_ff;
      pair_in       = pair_ff;
      last_in       = last_ff;
      rsp_valid_in  = rsp.ready ? 1'b0 : rsp_valid_ff;
      mem_req       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req.op == OP_LOAD) begin
                  if (!draining_ff) begin
                     mem_req.wr_en   = store_en;
                     mem_req.wr_addr = load_count_ff[ADDR_W-1:0];
                     mem_req.wr_data = req.value;
                     load_count_in   = load_count_ff + CNT_W'(store_en);
                     if (load_count_in >= cfg_n) begin
                        set_size_in = cfg_n;
                        read_ptr_in = '0;
                        if (cfg_n == CNT_W'(1)) begin
                           draining_in = 1'b1;
                        end else begin
                           k_in     = CNT_W'(2);
                           j_in     = ADDR_W'(1);
                           pair_in  = '0;
                           state_in = ST_READ;
                        end
                     end
                  end
               end else if (draining_ff) begin
                  mem_req.rd_en_a   = 1'b1;
                  mem_req.rd_addr_a = drain_idx;
                  rsp_valid_in      = 1'b1;
                  last_in           = drain_last;
                  if (drain_last) begin
                     draining_in   = 1'b0;
                     load_count_in = '0;
                     read_ptr_in   = '0;
                  end else begin
                     read_ptr_in = CNT_W'(drain_idx) + CNT_W'(1);
                  end
               end
            end
         end
         ST_READ: begin
            mem_req.rd_en_a   = 1'b1;
            mem_req.rd_addr_a = pair_lo;
            mem_req.rd_en_b   = 1'b1;
            mem_req.rd_addr_b = pair_hi;
            state_in          = ST_CMP;
         end
         ST_CMP: begin
            if (swap) begin
               state_in = ST_WR_LO;
            end else begin
               pair_in  = adv_pair;
               j_in     = adv_j;
               k_in     = adv_k;
               state_in = adv_done ? ST_IDLE : ST_READ;
               if (adv_done) begin
                  draining_in = 1'b1;
               end
            end
         end
         ST_WR_LO: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pair_lo;
            mem_req.wr_data = rd_data_b;
            state_in        = ST_WR_HI;
         end
         ST_WR_HI: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pair_hi;
            mem_req.wr_data = rd_data_a;
            pair_in         = adv_pair;
            j_in            = adv_j;
            k_in            = adv_k;
            state_in        = adv_done ? ST_IDLE : ST_READ;
            if (adv_done) begin
               draining_in = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         load_count_ff <= '0;
         read_ptr_ff   <= '0;
         set_size_ff   <= CNT_W'(1);
         draining_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         sort_up_ff    <= 1'b1;
         size_log2_ff  <= SIZE_LOG2_W'(10);
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         read_ptr_ff   <= read_ptr_in;
         set_size_ff   <= set_size_in;
         draining_ff   <= draining_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SORT_ASCENDING: sort_up_ff   <= csr_wdata[0];
               CSR_SIZE_LOG2:      size_log2_ff <= csr_wdata[SIZE_LOG2_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      k_ff    <= k_in;
      j_ff    <= j_in;
      pair_ff <= pair_in;
      last_ff <= last_in;
   end

endmodule

### sv/bitonic_sorter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter
// Loads a power-of-two set of signed words, sorts it in place with one shared
// compare-swap unit, then returns the sorted words one per unload request.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake       Carries
//   req_chan  in         valid/ready     op (load or unload), value
//   rsp_chan  out        valid/ready     sorted_value, last
//   csr_*     in         write enable    index 0 sort_ascending, 1 size_log2
//
// A load or unload is taken only while the block is idle. The load
// that completes the set starts the sort, during which req_chan is not ready.
// The sort walks (n/2) * L * (L+1) / 2 compare-swaps for n = 2**L values, each
// reading both entries and comparing them, then writing the lower and then the
// higher entry when the pair is swapped, since the store has a single write port.
// An unload of a sorted set returns its word in the next cycle; while that
// response waits on rsp_chan.ready, no new request is taken. Reset is
// synchronous and active high; the element store itself is not cleared, as
// every entry is written before it is read.
//
module bitonic_sorter_top (
   input  logic                               clock,
   input  logic                               reset,
   bsort_req_if.sink                          req_chan,
   bsort_rsp_if.source                        rsp_chan,
   input  logic                               csr_we,
   input  logic [bsort_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bsort_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bsort_pkg::*;

   bsort_mem_req_type  mem_req;
   logic [DATA_W-1:0]  rd_data_a;
   logic [DATA_W-1:0]  rd_data_b;
   logic               swap;
   logic               dir_up;

   // The controller owns both channels, the configuration registers and the
   // sort sequencer that steps through stages, distances and pairs.
   bsort_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .rsp       (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b),
      .swap      (swap),
      .dir_up    (dir_up),
      .mem_req   (mem_req)
   );

   // Port A serves both the lower entry of each pair and unload reads; its
   // registered output doubles as the response data register.
   bsort_store u_store (
      .clock     (clock),
      .mem_req   (mem_req),
      .rd_data_a (rd_data_a),
      .rd_data_b (rd_data_b)
   );

   // The single compare unit decides every swap of the sort.
   bsort_cmp u_cmp (
      .lo_value (rd_data_a),
      .hi_value (rd_data_b),
      .dir_up   (dir_up),
      .swap     (swap)
   );

endmodule

### sv/bsort_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitonic sorter port checker
// Watches the top-level ports for response ordering and stall behavior.
// ----------------------------------------------------------------------------
module bsort_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic req_op,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);
   import bsort_pkg::*;

   // A response is held until it is transferred.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // No request is taken while a response is stalled.
   a_no_accept_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   // A new response only follows an accepted unload request.
   a_rsp_from_unload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid && !rsp_ready) |->
         $past(req_valid && req_ready && (req_op == OP_UNLOAD)))
      else $error("response without unload request");

   // After the final value of a set, the next response cannot follow at once.
   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("response right after final value");

endmodule

bind bitonic_sorter_top bsort_checker u_bsort_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_op    (req_chan.op),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_last  (rsp_chan.last)
);
